FILE: rtl/core/mips_subset_instruction_execute_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the execute unit checker
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MIPS_SUBSET_INSTRUCTION_EXECUTE_UNIT_ASSERT_SVH
`define MIPS_SUBSET_INSTRUCTION_EXECUTE_UNIT_ASSERT_SVH

// condition must hold at every clock edge out of reset
`define MSIE_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// when ante holds, cons must hold at the next clock edge
`define MSIE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/msie_pkg.sv
// ----------------------------------------------------------------------------
// msie_pkg
// Shared types, command and status codes for the integer execute unit.
// ----------------------------------------------------------------------------
package msie_pkg;

    localparam int DATA_DEPTH_DEF = 65536;
    localparam int REG_COUNT      = 32;
    localparam int COST_W         = 52;

    localparam logic [4:0] ZERO_INDEX = 5'd0;
    localparam logic [4:0] SP_INDEX   = 5'd29;
    localparam logic [4:0] RA_INDEX   = 5'd31;

    localparam logic [3:0] ADDI_COST = 4'd4;

    localparam logic [3:0] CMD_ADD  = 4'd0;
    localparam logic [3:0] CMD_SUB  = 4'd1;
    localparam logic [3:0] CMD_SLL  = 4'd2;
    localparam logic [3:0] CMD_SRL  = 4'd3;
    localparam logic [3:0] CMD_SW   = 4'd4;
    localparam logic [3:0] CMD_LW   = 4'd5;
    localparam logic [3:0] CMD_BNE  = 4'd6;
    localparam logic [3:0] CMD_BEQ  = 4'd7;
    localparam logic [3:0] CMD_BLEZ = 4'd8;
    localparam logic [3:0] CMD_BGTZ = 4'd9;
    localparam logic [3:0] CMD_J    = 4'd10;
    localparam logic [3:0] CMD_JR   = 4'd11;
    localparam logic [3:0] CMD_JAL  = 4'd12;
    localparam logic [3:0] CMD_ADDI = 4'd13;
    localparam logic [3:0] CMD_END  = 4'd14;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_END     = 2'd1;
    localparam logic [1:0] ST_BAD_CMD = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    typedef struct packed {
        logic [3:0]         command;
        logic [4:0]         dest_index;
        logic [4:0]         src_index_a;
        logic [4:0]         src_index_b;
        logic signed [31:0] immediate;
    } in_item_t;

    typedef struct packed {
        logic [31:0]        next_pc;
        logic [1:0]         status;
        logic               reg_written;
        logic [4:0]         written_reg;
        logic signed [31:0] written_value;
        logic               mem_written;
        logic [15:0]        mem_address;
        logic [31:0]        cycle_total;
        logic [31:0]        executed_total;
    } out_item_t;

    typedef struct packed {
        logic        en;
        logic [4:0]  idx;
        logic [31:0] data;
    } rf_write_t;

    // cost nibble of commands add..jal, zero for the rest
    function automatic logic [3:0] cost_of(input logic [COST_W-1:0] tab,
                                           input logic [3:0] cmd);
        logic [3:0] c;
        c = '0;
        if (cmd <= CMD_JAL)
            c = tab[{cmd, 2'b00} +: 4];
        return c;
    endfunction

endpackage

FILE: rtl/core/msie_regfile.sv
// ----------------------------------------------------------------------------
// msie_regfile
// 32x32 register file, two banks (ports a/b and port d), registered reads,
// per-entry valid bits standing in for the reset contents, write-through.
// ----------------------------------------------------------------------------
module msie_regfile
    import msie_pkg::*;
#(
    parameter int DATA_DEPTH = DATA_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rd_en,
    input  logic [4:0]  rd_idx_a,
    input  logic [4:0]  rd_idx_b,
    input  logic [4:0]  rd_idx_d,
    input  rf_write_t   wr,
    output logic [31:0] rd_data_a,
    output logic [31:0] rd_data_b,
    output logic [31:0] rd_data_d
);

    localparam logic [31:0] SP_RESET = 32'(DATA_DEPTH - 1);

    logic [31:0] bank_ab_mem [REG_COUNT];
    logic [31:0] bank_d_mem  [REG_COUNT];

    logic [REG_COUNT-1:0] valid_reg;
    logic [31:0] mem_a_reg, mem_b_reg, mem_d_reg, fwd_data_reg;
    logic [4:0]  idx_a_reg, idx_b_reg, idx_d_reg;
    logic        vld_a_reg, vld_b_reg, vld_d_reg;
    logic        hit_a_reg, hit_b_reg, hit_d_reg;

    function automatic logic [31:0] reset_value(input logic [4:0] idx);
        return (idx == SP_INDEX) ? SP_RESET : 32'd0;
    endfunction

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            bank_ab_mem[wr.idx] <= wr.data;
            bank_d_mem[wr.idx]  <= wr.data;
        end
        if (rd_en)
        begin
            mem_a_reg    <= bank_ab_mem[rd_idx_a];
            mem_b_reg    <= bank_ab_mem[rd_idx_b];
            mem_d_reg    <= bank_d_mem[rd_idx_d];
            idx_a_reg    <= rd_idx_a;
            idx_b_reg    <= rd_idx_b;
            idx_d_reg    <= rd_idx_d;
            fwd_data_reg <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_d_reg <= 1'b0;
            hit_a_reg <= 1'b0;
            hit_b_reg <= 1'b0;
            hit_d_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
                valid_reg[wr.idx] <= 1'b1;
            if (rd_en)
            begin
                vld_a_reg <= valid_reg[rd_idx_a];
                vld_b_reg <= valid_reg[rd_idx_b];
                vld_d_reg <= valid_reg[rd_idx_d];
                // write in the same edge as the read: old data in the bank
                hit_a_reg <= wr.en && (wr.idx == rd_idx_a);
                hit_b_reg <= wr.en && (wr.idx == rd_idx_b);
                hit_d_reg <= wr.en && (wr.idx == rd_idx_d);
            end
        end
    end

    assign rd_data_a = hit_a_reg ? fwd_data_reg :
                       vld_a_reg ? mem_a_reg : reset_value(idx_a_reg);
    assign rd_data_b = hit_b_reg ? fwd_data_reg :
                       vld_b_reg ? mem_b_reg : reset_value(idx_b_reg);
    assign rd_data_d = hit_d_reg ? fwd_data_reg :
                       vld_d_reg ? mem_d_reg : reset_value(idx_d_reg);

endmodule

FILE: rtl/core/msie_dmem.sv
// ----------------------------------------------------------------------------
// msie_dmem
// Word data memory, single port, registered read, zero sweep after reset.
// ----------------------------------------------------------------------------
module msie_dmem
    import msie_pkg::*;
#(
    parameter int DATA_DEPTH = DATA_DEPTH_DEF,
    parameter int AW         = $clog2(DATA_DEPTH)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [31:0]   wdata,
    output logic [31:0]   rdata,
    output logic          busy
);

    logic [31:0]   data_mem [DATA_DEPTH];
    logic [31:0]   rdata_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          clearing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_addr_reg == AW'(DATA_DEPTH - 1))
                clearing_reg <= 1'b0;
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
            data_mem[clr_addr_reg] <= '0;
        else if (en && we)
            data_mem[addr] <= wdata;
        if (en && !we)
            rdata_reg <= data_mem[addr];
    end

    assign rdata = rdata_reg;
    assign busy  = clearing_reg;

endmodule

FILE: rtl/core/msie_outq.sv
// ----------------------------------------------------------------------------
// msie_outq
// Two-entry result queue between the execute pipe and the output channel.
// ----------------------------------------------------------------------------
module msie_outq
    import msie_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  out_item_t push_item,
    input  logic      out_stall,
    output logic      out_valid,
    output out_item_t out_item,
    output logic [1:0] count
);

    out_item_t  entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && !out_stall;
    assign out_item  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

FILE: rtl/core/mips_subset_instruction_execute_unit.sv
// ----------------------------------------------------------------------------
// mips_subset_instruction_execute_unit
// Executes one decoded integer instruction per item against a register file,
// a word data memory, a program counter and cycle/instruction totals.
// ----------------------------------------------------------------------------
// Usage:
//   in_item (valid/stall): command, register indices, immediate. Taken when
//   in_valid is high and in_stall is low.
//   out_item (valid/stall): one result per instruction, in order, held while
//   out_stall is high. Up to two results are queued before in_stall rises.
//   cfg (valid/ready): 52-bit cycle cost table, always ready; write it only
//   while no instruction is in flight.
// Timing: an item reads the register file at acceptance, executes and
//   accesses data memory in the next cycle, is registered in stage s2 and
//   is then pushed into the output queue, which raises out_valid. No new
//   item is taken while one executes: the register read and the execute
//   cycle form a loop that the next instruction depends on.
// Reset: registers read zero (stack pointer DATA_DEPTH-1); data memory is
//   swept to zero, one word per cycle, and in_stall stays high until the
//   sweep ends. The cost table resets to zero.
// Stall: a stalled output keeps its item; once two results wait, in_stall
//   stays high until the receiver takes one.
// ----------------------------------------------------------------------------
module mips_subset_instruction_execute_unit
    import msie_pkg::*;
#(
    parameter int DATA_DEPTH = DATA_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_item,
    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [COST_W-1:0] cfg_data
);

    localparam int AW = $clog2(DATA_DEPTH);

    logic [COST_W-1:0] cost_table_reg;
    logic [31:0]       pc_reg, cycle_reg, instr_reg;
    logic              halted_reg;

    logic      s1_valid_reg;
    in_item_t  s1_item_reg;
    logic      s2_valid_reg;
    out_item_t s2_item_reg;
    logic      s2_is_lw_reg;

    logic        accept;
    logic [1:0]  q_count;
    logic        dmem_busy;
    logic [31:0] dmem_rdata;
    logic [31:0] va, vb, vd;
    rf_write_t   rf_wr;
    out_item_t   s2_result;

    // execute stage
    logic [31:0] imm, pc_inc, addr;
    logic        in_range;
    out_item_t   ex_item;
    logic        ex_is_lw, ex_counted, ex_halt;
    logic [3:0]  ex_cost;
    logic [31:0] pc_next, cycle_next, instr_next;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && !in_stall;
    assign in_stall  = dmem_busy || s1_valid_reg ||
                       (({1'b0, s2_valid_reg} + q_count) >= 2'd2);

    msie_regfile #(
        .DATA_DEPTH (DATA_DEPTH)
    ) u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_idx_a  (in_item.src_index_a),
        .rd_idx_b  (in_item.src_index_b),
        .rd_idx_d  (in_item.dest_index),
        .wr        (rf_wr),
        .rd_data_a (va),
        .rd_data_b (vb),
        .rd_data_d (vd)
    );

    always_comb
    begin
        imm        = s1_item_reg.immediate;
        pc_inc     = pc_reg + 32'd1;
        addr       = imm + va;
        in_range   = (addr < 32'(DATA_DEPTH));
        pc_next    = pc_inc;
        ex_is_lw   = 1'b0;
        ex_counted = 1'b1;
        ex_halt    = 1'b0;
        ex_item    = '0;
        ex_item.status      = ST_OK;
        ex_item.written_reg = s1_item_reg.dest_index;

        unique case (s1_item_reg.command) inside
            CMD_ADD:
            begin
                ex_item.reg_written   = 1'b1;
                ex_item.written_value = va + vb;
            end
            CMD_SUB:
            begin
                ex_item.reg_written   = 1'b1;
                ex_item.written_value = va - vb;
            end
            CMD_SLL:
            begin
                ex_item.reg_written   = 1'b1;
                ex_item.written_value = va << imm[4:0];
            end
            CMD_SRL:
            begin
                ex_item.reg_written   = 1'b1;
                ex_item.written_value = va >> imm[4:0];
            end
            CMD_SW, CMD_LW:
            begin
                ex_item.mem_address = addr[15:0];
                if (!in_range)
                    ex_item.status = ST_RANGE;
                else if (s1_item_reg.command == CMD_SW)
                    ex_item.mem_written = 1'b1;
                else
                begin
                    ex_item.reg_written = 1'b1;
                    ex_is_lw            = 1'b1;
                end
            end
            CMD_BNE:  if (vd != vb) pc_next = pc_inc + imm;
            CMD_BEQ:  if (vd == vb) pc_next = pc_inc + imm;
            CMD_BLEZ: if ($signed(vd) <= 0) pc_next = pc_inc + imm;
            CMD_BGTZ: if ($signed(vd) > 0) pc_next = pc_inc + imm;
            CMD_J:    pc_next = imm;
            CMD_JR:   pc_next = vd;
            CMD_JAL:
            begin
                ex_item.reg_written   = 1'b1;
                ex_item.written_reg   = RA_INDEX;
                ex_item.written_value = pc_inc;
                pc_next               = imm;
            end
            CMD_ADDI:
            begin
                ex_item.reg_written   = 1'b1;
                ex_item.written_value = va + imm;
            end
            CMD_END:
            begin
                ex_item.status = ST_END;
                ex_counted     = 1'b0;
                ex_halt        = 1'b1;
            end
            default:
            begin
                ex_item.status = ST_BAD_CMD;
                ex_counted     = 1'b0;
                ex_halt        = 1'b1;
            end
        endcase

        // register zero stays zero
        if (ex_item.written_reg == ZERO_INDEX)
            ex_item.reg_written = 1'b0;
        if (!ex_item.reg_written)
        begin
            ex_item.written_reg   = ZERO_INDEX;
            ex_item.written_value = '0;
            ex_is_lw              = 1'b0;
        end

        ex_cost    = (s1_item_reg.command == CMD_ADDI) ? ADDI_COST
                   : cost_of(cost_table_reg, s1_item_reg.command);
        cycle_next = ex_counted ? cycle_reg + {28'd0, ex_cost} : cycle_reg;
        instr_next = ex_counted ? instr_reg + 32'd1 : instr_reg;

        if (halted_reg)
        begin
            ex_item        = '0;
            ex_item.status = ST_END;
            ex_is_lw       = 1'b0;
            ex_halt        = 1'b1;
            pc_next        = pc_reg;
            cycle_next     = cycle_reg;
            instr_next     = instr_reg;
        end

        ex_item.next_pc        = pc_next;
        ex_item.cycle_total    = cycle_next;
        ex_item.executed_total = instr_next;
    end

    msie_dmem #(
        .DATA_DEPTH (DATA_DEPTH),
        .AW         (AW)
    ) u_dmem (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (s1_valid_reg && (ex_item.mem_written || ex_is_lw)),
        .we    (ex_item.mem_written),
        .addr  (addr[AW-1:0]),
        .wdata (vd),
        .rdata (dmem_rdata),
        .busy  (dmem_busy)
    );

    always_comb
    begin
        s2_result = s2_item_reg;
        if (s2_is_lw_reg)
            s2_result.written_value = dmem_rdata;
        rf_wr.en   = s2_valid_reg && s2_item_reg.reg_written;
        rf_wr.idx  = s2_item_reg.written_reg;
        rf_wr.data = s2_result.written_value;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_item_reg <= in_item;
        if (s1_valid_reg)
        begin
            s2_item_reg  <= ex_item;
            s2_is_lw_reg <= ex_is_lw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cost_table_reg <= '0;
            pc_reg         <= '0;
            cycle_reg      <= '0;
            instr_reg      <= '0;
            halted_reg     <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                cost_table_reg <= cfg_data;
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                pc_reg     <= pc_next;
                cycle_reg  <= cycle_next;
                instr_reg  <= instr_next;
                halted_reg <= halted_reg || ex_halt;
            end
        end
    end

    msie_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s2_valid_reg),
        .push_item (s2_result),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_item  (out_item),
        .count     (q_count)
    );

endmodule

FILE: rtl/core/msie_checker.sv
// ----------------------------------------------------------------------------
// msie_checker
// Port-level checks on the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "mips_subset_instruction_execute_unit_assert.svh"

module msie_checker
    import msie_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input in_item_t          in_item,
    input logic              out_valid,
    input logic              out_stall,
    input out_item_t         out_item,
    input logic              cfg_valid,
    input logic              cfg_ready,
    input logic [COST_W-1:0] cfg_data
);

    `MSIE_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(out_item), "stalled result item changed")

    `MSIE_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall,
        in_stall, "item accepted while the previous one executes")

    `MSIE_ASSERT_ALWAYS(a_no_zero_write,
        !(out_valid && out_item.reg_written) || (out_item.written_reg != ZERO_INDEX),
        "register zero reported as written")

    `MSIE_ASSERT_ALWAYS(a_store_clean,
        !(out_valid && out_item.mem_written) ||
        (!out_item.reg_written && (out_item.status == ST_OK)),
        "store reported with a register write or a bad status")

endmodule

bind mips_subset_instruction_execute_unit msie_checker u_msie_checker (.*);

FILE: tb/msie_execute_check.sv
// ----------------------------------------------------------------------------
// msie_execute_check
// Watches the instruction, result and cost table channels of the execute
// unit. Keeps its own register file, data memory, pc and totals, predicts
// the result of every accepted item and compares each delivered result with
// the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module msie_execute_check
    import msie_pkg::*;
#(
    parameter int DATA_DEPTH = DATA_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  in_item_t          in_item,
    input  logic              out_valid,
    input  logic              out_stall,
    input  out_item_t         out_item,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [COST_W-1:0] cfg_data,
    output int                failures,
    output int                pending
);

    logic [COST_W-1:0] cost_table;
    logic [31:0]       regs [REG_COUNT];
    logic [31:0]       data_mem [int unsigned];
    logic [31:0]       pc;
    logic [31:0]       cycles;
    logic [31:0]       executed;
    logic              halted;

    out_item_t predicted_results [$];
    out_item_t want;
    int        err_count = 0;

    // executes one instruction against the shadow state, returns its result
    function automatic out_item_t execute_instr(input in_item_t ins);
        out_item_t         r;
        logic [31:0]       vd, va, vb, imm, pc_n, wval, addr;
        logic [COST_W-1:0] shifted;
        logic [4:0]        wreg;
        logic [1:0]        st;
        logic              wr, mw, counted;

        r = '0;
        if (halted)
        begin
            r.next_pc        = pc;
            r.status         = ST_END;
            r.cycle_total    = cycles;
            r.executed_total = executed;
            return r;
        end

        vd      = regs[ins.dest_index];
        va      = regs[ins.src_index_a];
        vb      = regs[ins.src_index_b];
        imm     = ins.immediate;
        pc_n    = pc + 32'd1;
        st      = ST_OK;
        wr      = 1'b0;
        mw      = 1'b0;
        counted = 1'b1;
        wreg    = ins.dest_index;
        wval    = '0;

        case (ins.command)
            CMD_ADD:  begin wr = 1'b1; wval = va + vb; end
            CMD_SUB:  begin wr = 1'b1; wval = va - vb; end
            CMD_SLL:  begin wr = 1'b1; wval = va << imm[4:0]; end
            CMD_SRL:  begin wr = 1'b1; wval = va >> imm[4:0]; end
            CMD_SW, CMD_LW:
            begin
                addr = imm + va;
                r.mem_address = addr[15:0];
                if (addr >= DATA_DEPTH)
                    st = ST_RANGE;
                else if (ins.command == CMD_SW)
                begin
                    data_mem[addr] = vd;
                    mw = 1'b1;
                end
                else
                begin
                    wr   = 1'b1;
                    wval = data_mem.exists(addr) ? data_mem[addr] : 32'd0;
                end
            end
            CMD_BNE:  if (vd != vb) pc_n = pc_n + imm;
            CMD_BEQ:  if (vd == vb) pc_n = pc_n + imm;
            CMD_BLEZ: if ($signed(vd) <= 0) pc_n = pc_n + imm;
            CMD_BGTZ: if ($signed(vd) > 0) pc_n = pc_n + imm;
            CMD_J:    pc_n = imm;
            CMD_JR:   pc_n = vd;
            CMD_JAL:
            begin
                wr   = 1'b1;
                wreg = RA_INDEX;
                wval = pc_n;
                pc_n = imm;
            end
            CMD_ADDI: begin wr = 1'b1; wval = va + imm; end
            CMD_END:
            begin
                st      = ST_END;
                counted = 1'b0;
                halted  = 1'b1;
            end
            default:
            begin
                st      = ST_BAD_CMD;
                counted = 1'b0;
                halted  = 1'b1;
            end
        endcase

        if (counted)
        begin
            shifted  = cost_table >> (4 * ins.command);
            cycles   = cycles + ((ins.command == CMD_ADDI) ? 32'(ADDI_COST)
                                                           : 32'(shifted[3:0]));
            executed = executed + 32'd1;
        end
        // register zero stays zero, the write is reported as none
        if (wr && wreg == ZERO_INDEX)
            wr = 1'b0;
        if (wr)
            regs[wreg] = wval;
        pc = pc_n;

        r.next_pc        = pc_n;
        r.status         = st;
        r.reg_written    = wr;
        r.written_reg    = wr ? wreg : 5'd0;
        r.written_value  = wr ? wval : 32'd0;
        r.mem_written    = mw;
        r.cycle_total    = cycles;
        r.executed_total = executed;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
        if (exp_val !== got_val)
        begin
            $error("%s: expected %0h, got %0h", field, exp_val, got_val);
            err_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cost_table = '0;
            for (int i = 0; i < REG_COUNT; i++)
                regs[i] = '0;
            regs[SP_INDEX] = 32'(DATA_DEPTH - 1);
            data_mem.delete();
            pc       = '0;
            cycles   = '0;
            executed = '0;
            halted   = 1'b0;
            predicted_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                cost_table = cfg_data;
            if (in_valid && !in_stall)
                predicted_results.insert(predicted_results.size(),
                                         execute_instr(in_item));
            if (out_valid && !out_stall)
            begin
                if (predicted_results.size() == 0)
                begin
                    $error("result item arrived with no prediction waiting");
                    err_count++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    check_field("next_pc", want.next_pc, out_item.next_pc);
                    check_field("status", want.status, out_item.status);
                    check_field("reg_written", want.reg_written, out_item.reg_written);
                    check_field("written_reg", want.written_reg, out_item.written_reg);
                    check_field("written_value", want.written_value,
                                out_item.written_value);
                    check_field("mem_written", want.mem_written, out_item.mem_written);
                    check_field("mem_address", want.mem_address, out_item.mem_address);
                    check_field("cycle_total", want.cycle_total, out_item.cycle_total);
                    check_field("executed_total", want.executed_total,
                                out_item.executed_total);
                end
            end
        end
        pending  <= predicted_results.size();
        failures <= err_count;
    end

endmodule

FILE: tb/tb_mips_subset_instruction_execute_unit.sv
// ----------------------------------------------------------------------------
// tb_mips_subset_instruction_execute_unit
// Drives decoded instructions and cost table writes into the execute unit:
// a directed opening, then random programs under several cost tables, with
// random idling on both channels, one long output hold-off and a halt at the
// end. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_mips_subset_instruction_execute_unit;
    import msie_pkg::*;

    localparam int         CLK_PERIOD   = 4;
    localparam int         LIMIT_CYCLES = 400000;
    localparam int         HOLD_CYCLES  = 80;
    localparam logic [3:0] CMD_INVALID  = 4'd15;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    in_item_t          in_item;
    logic              out_valid;
    logic              out_stall;
    out_item_t         out_item;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [COST_W-1:0] cfg_data;

    int failure_count;
    int results_pending;
    bit calm;
    bit hold_req;
    bit hold_done;

    mips_subset_instruction_execute_unit #(
        .DATA_DEPTH (DATA_DEPTH_DEF)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    msie_execute_check #(
        .DATA_DEPTH (DATA_DEPTH_DEF)
    ) u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .failures  (failure_count),
        .pending   (results_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: random stalls, one long hold-off when asked
    initial
    begin
        out_stall <= 1'b0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                out_stall <= !calm && ($urandom_range(99) < 11);
        end
    end

    function automatic in_item_t make_instr(input logic [3:0] cmd, input logic [4:0] rd,
                                            input logic [4:0] ra, input logic [4:0] rb,
                                            input logic [31:0] imm);
        in_item_t ins;
        ins.command     = cmd;
        ins.dest_index  = rd;
        ins.src_index_a = ra;
        ins.src_index_b = rb;
        ins.immediate   = imm;
        return ins;
    endfunction

    function automatic logic [COST_W-1:0] random_costs();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[COST_W-1:0];
    endfunction

    // random instruction of a running program, never one that halts
    function automatic in_item_t random_instr();
        in_item_t ins;
        int       pick;
        pick = $urandom_range(99);
        ins.dest_index  = 5'($urandom_range(31));
        ins.src_index_a = 5'($urandom_range(31));
        ins.src_index_b = 5'($urandom_range(31));
        ins.immediate   = $urandom;
        if ($urandom_range(1))
            ins.immediate = 32'($urandom_range(64)) - 32'd32;

        if (pick < 25)
            ins.command = CMD_ADDI;
        else if (pick < 35)
            ins.command = CMD_ADD;
        else if (pick < 45)
            ins.command = CMD_SUB;
        else if (pick < 51)
            ins.command = CMD_SLL;
        else if (pick < 57)
            ins.command = CMD_SRL;
        else if (pick < 81)
        begin
            ins.command = (pick < 69) ? CMD_SW : CMD_LW;
            // mostly a small pool of addresses so loads see earlier stores
            case ($urandom_range(9))
                0, 1: ;
                2:
                begin
                    ins.src_index_a = ZERO_INDEX;
                    ins.immediate   = 32'(DATA_DEPTH_DEF - 2 + $urandom_range(3));
                end
                3:
                    ins.src_index_a = SP_INDEX;
                default:
                begin
                    ins.src_index_a = ZERO_INDEX;
                    ins.immediate   = $urandom_range(1) ? 32'($urandom_range(31))
                                      : 32'(DATA_DEPTH_DEF - 1 - $urandom_range(31));
                end
            endcase
        end
        else if (pick < 85)
            ins.command = CMD_BNE;
        else if (pick < 89)
        begin
            ins.command = CMD_BEQ;
            if ($urandom_range(1))
                ins.src_index_b = ins.dest_index;
        end
        else if (pick < 92)
            ins.command = CMD_BLEZ;
        else if (pick < 95)
            ins.command = CMD_BGTZ;
        else if (pick < 97)
            ins.command = CMD_J;
        else if (pick < 98)
            ins.command = CMD_JR;
        else
            ins.command = CMD_JAL;
        return ins;
    endfunction

    task automatic send_instr(input in_item_t ins);
        if (!calm && $urandom_range(99) < 11)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= ins;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic run_program(input int count);
        for (int i = 0; i < count; i++)
            send_instr(random_instr());
    endtask

    // wait until every predicted result has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cost_table(input logic [COST_W-1:0] costs);
        cfg_valid <= 1'b1;
        cfg_data  <= costs;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [3:0] first_halt;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        calm      <= 1'b0;
        hold_req  <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        write_cost_table('1);

        // extremes of values, overflow, shifts, memory edges, register zero
        send_instr(make_instr(CMD_ADDI, 5'd1, ZERO_INDEX, 5'd0, 32'h7FFF_FFFF));
        send_instr(make_instr(CMD_ADDI, 5'd2, ZERO_INDEX, 5'd0, 32'h8000_0000));
        send_instr(make_instr(CMD_ADDI, 5'd3, ZERO_INDEX, 5'd0, 32'hFFFF_FFFF));
        send_instr(make_instr(CMD_ADD, 5'd4, 5'd1, 5'd1, 32'd0));
        send_instr(make_instr(CMD_SUB, 5'd5, 5'd2, 5'd1, 32'd0));
        send_instr(make_instr(CMD_SLL, 5'd6, 5'd3, 5'd0, 32'd31));
        send_instr(make_instr(CMD_SRL, 5'd7, 5'd3, 5'd31, 32'hFFFF_FFFF));
        send_instr(make_instr(CMD_SW, 5'd1, ZERO_INDEX, 5'd0, 32'd0));
        send_instr(make_instr(CMD_SW, 5'd3, ZERO_INDEX, 5'd0, 32'(DATA_DEPTH_DEF - 1)));
        send_instr(make_instr(CMD_LW, 5'd8, SP_INDEX, 5'd0, 32'd0));
        send_instr(make_instr(CMD_LW, 5'd9, ZERO_INDEX, 5'd0, 32'd0));
        send_instr(make_instr(CMD_LW, 5'd10, ZERO_INDEX, 5'd0, 32'd123));
        send_instr(make_instr(CMD_LW, 5'd11, ZERO_INDEX, 5'd0, 32'(DATA_DEPTH_DEF)));
        send_instr(make_instr(CMD_SW, 5'd1, 5'd3, 5'd0, 32'd0));
        send_instr(make_instr(CMD_ADDI, ZERO_INDEX, 5'd1, 5'd0, 32'd5));
        send_instr(make_instr(CMD_BNE, 5'd1, 5'd0, 5'd2, 32'hFFFF_FFF9));
        send_instr(make_instr(CMD_BEQ, 5'd1, 5'd0, 5'd1, 32'd3));
        send_instr(make_instr(CMD_BEQ, 5'd1, 5'd0, 5'd2, 32'd3));
        send_instr(make_instr(CMD_BLEZ, 5'd2, 5'd0, 5'd0, 32'hFFFF_FF9C));
        send_instr(make_instr(CMD_BGTZ, 5'd1, 5'd0, 5'd0, 32'd40));
        send_instr(make_instr(CMD_BGTZ, 5'd3, 5'd0, 5'd0, 32'd40));
        send_instr(make_instr(CMD_J, 5'd0, 5'd0, 5'd0, 32'hFFFF_FFFF));
        send_instr(make_instr(CMD_JAL, 5'd0, 5'd0, 5'd0, 32'd100));
        send_instr(make_instr(CMD_JR, RA_INDEX, 5'd0, 5'd0, 32'd0));
        run_program(150);
        drain();

        // long output hold-off while items keep coming
        write_cost_table(random_costs());
        run_program(50);
        hold_req <= 1'b1;
        run_program(150);
        drain();

        // no idling on either side
        write_cost_table('0);
        calm <= 1'b1;
        run_program(175);
        drain();
        calm <= 1'b0;

        write_cost_table(random_costs());
        run_program(200);

        // halt last, then a few items that must see the held state
        first_halt = $urandom_range(1) ? CMD_END : CMD_INVALID;
        send_instr(make_instr(first_halt, 5'($urandom_range(31)), 5'($urandom_range(31)),
                              5'($urandom_range(31)), $urandom));
        send_instr(make_instr((first_halt == CMD_END) ? CMD_INVALID : CMD_END,
                              5'd0, 5'd0, 5'd0, 32'd0));
        run_program(3);
        drain();
        repeat (8) @(posedge clk);

        if (failure_count == 0 && results_pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
